// ===== design/brsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_pkg
// shared types, constants and a ones count function for the bit store unit
// ----------------------------------------------------------------------------
package brsc_pkg;

    localparam int KIND_W   = 3;
    localparam int LOW_W    = 12;
    localparam int HIGH_W   = 13;
    localparam int LEN_W    = 13;
    localparam int ANSWER_W = 13;
    localparam int WORD_BITS = 8;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RANGE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COUNT = 3'd4;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_WRITE,
        OP_COUNT,
        OP_GET
    } t_op;

    function automatic logic [3:0] ones8(input logic [7:0] w);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            c = c + {3'd0, w[k]};
        end
        return c;
    endfunction

endpackage

// ===== design/brsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_front
// accepts items, modulo and clamp, passing ones become word span commands
// ----------------------------------------------------------------------------
module brsc_front
    import brsc_pkg::*;
#(
    parameter int MAX_BITS = 4096,
    parameter int BIT_W    = 12,
    parameter int WADDR_W  = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [LOW_W-1:0]    i_index_low,
    input  logic [HIGH_W-1:0]   i_index_high,
    input  logic                i_bit_value,
    input  logic [LEN_W-1:0]    i_length,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output t_op                 o_cmd_op,
    output logic [BIT_W-1:0]    o_cmd_lo,
    output logic [BIT_W:0]      o_cmd_hi,
    output logic [WADDR_W-1:0]  o_cmd_w_first,
    output logic [WADDR_W-1:0]  o_cmd_w_last,
    output logic                o_cmd_val
);
    localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int XW = (LOW_W > BIT_W + 1 ? LOW_W : BIT_W + 1) + 2;

    logic [XW-1:0] w_lo_x, w_hi_x, w_len_x, w_nw;
    logic [BIT_W-1:0] w_lo;
    logic [BIT_W:0] w_hi;
    logic w_pass, w_emit;
    t_op w_op;
    logic [WADDR_W-1:0] w_first, w_last;

    logic r_valid;
    t_op r_op;
    logic [BIT_W-1:0] r_lo;
    logic [BIT_W:0] r_hi;
    logic [WADDR_W-1:0] r_first, r_last;
    logic r_val;

    assign o_ready = !r_valid || i_cmd_ready;

    always_comb begin
        // modulo by shifted compare and subtract
        w_lo_x  = XW'(i_index_low);
        for (int s = LOW_W - 1; s >= 0; s--) begin
            if ((longint'(MAX_BITS) << s) <= longint'(w_lo_x)) begin
                w_lo_x = w_lo_x - XW'(longint'(MAX_BITS) << s);
            end
        end
        w_hi_x  = XW'(i_index_high);
        if (w_hi_x > XW'(MAX_BITS)) begin
            w_hi_x = XW'(MAX_BITS);
        end
        w_lo = BIT_W'(w_lo_x);
        w_hi = (BIT_W+1)'(w_hi_x);
        w_len_x = XW'(i_length) + XW'(7);
        w_nw = w_len_x >> 3;
        if (w_nw > XW'(NWORDS)) begin
            w_nw = XW'(NWORDS);
        end
        w_op = OP_GET;
        w_pass = 1'b0;
        w_emit = 1'b1;
        w_first = WADDR_W'(w_lo >> 3);
        w_last = w_first;
        case (i_kind)
            KIND_CLEAR: begin
                w_op = OP_CLEAR;
                w_first = '0;
                w_last = WADDR_W'(w_nw - XW'(1));
                w_pass = (w_nw != '0);
            end
            KIND_GET: begin
                w_op = OP_GET;
                w_pass = 1'b1;
            end
            KIND_SET: begin
                w_op = OP_WRITE;
                w_pass = 1'b1;
            end
            KIND_RANGE, KIND_COUNT: begin
                w_op = (i_kind == KIND_RANGE) ? OP_WRITE : OP_COUNT;
                w_emit = ({1'b0, w_lo} < w_hi);
                w_pass = w_emit || (i_kind == KIND_COUNT);
                w_last = w_emit ? WADDR_W'((w_hi - 1'b1) >> 3) : w_first;
            end
            default: begin
                w_pass = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && w_pass;
        end
        if (o_ready) begin
            r_op    <= w_op;
            r_val   <= i_bit_value;
            r_first <= w_first;
            r_last  <= w_last;
            if (i_kind == KIND_SET) begin
                r_lo <= w_lo;
                r_hi <= {1'b0, w_lo} + 1'b1;
            end else if (!w_emit) begin
                // empty count: zero mask
                r_lo <= '0;
                r_hi <= '0;
            end else begin
                r_lo <= w_lo;
                r_hi <= w_hi;
            end
        end
    end

    assign o_cmd_valid   = r_valid;
    assign o_cmd_op      = r_op;
    assign o_cmd_lo      = r_lo;
    assign o_cmd_hi      = r_hi;
    assign o_cmd_w_first = r_first;
    assign o_cmd_w_last  = r_last;
    assign o_cmd_val     = r_val;

endmodule

// ===== design/brsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_back
// walks the word span in store memory: read, work per word; clear skips read
// ----------------------------------------------------------------------------
module brsc_back
    import brsc_pkg::*;
#(
    parameter int MAX_BITS = 4096,
    parameter int BIT_W    = 12,
    parameter int WADDR_W  = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  t_op                  i_cmd_op,
    input  logic [BIT_W-1:0]     i_cmd_lo,
    input  logic [BIT_W:0]       i_cmd_hi,
    input  logic [WADDR_W-1:0]   i_cmd_w_first,
    input  logic [WADDR_W-1:0]   i_cmd_w_last,
    input  logic                 i_cmd_val,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ANSWER_W-1:0]  o_answer
);
    localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int CNT_W  = BIT_W + 2;
    localparam logic [CNT_W-1:0] ANS_MAX = CNT_W'((1 << ANSWER_W) - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_WORK,
        ST_OUT
    } t_state;

    logic [7:0] r_mem [NWORDS];
    logic [3:0] r_ones [NWORDS];
    logic [7:0] r_rd_word;
    logic [3:0] r_rd_ones;

    t_state r_state;
    t_op r_op;
    logic [BIT_W-1:0] r_lo;
    logic [BIT_W:0] r_hi;
    logic [WADDR_W-1:0] r_w, r_last;
    logic r_val;
    logic [CNT_W-1:0] r_cnt;
    logic r_out_valid;
    logic [ANSWER_W-1:0] r_answer;

    logic [7:0] w_mask, w_new;
    logic [BIT_W+3:0] w_base;
    logic w_we;
    logic [WADDR_W-1:0] w_waddr;
    logic [7:0] w_wdata;

    always_comb begin
        w_base = (BIT_W+4)'(r_w) << 3;
        for (int k = 0; k < 8; k++) begin
            w_mask[7-k] = ((w_base + (BIT_W+4)'(k)) >= (BIT_W+4)'(r_lo))
                       && ((w_base + (BIT_W+4)'(k)) < (BIT_W+4)'(r_hi));
        end
        w_new = r_val ? (r_rd_word | w_mask) : (r_rd_word & ~w_mask);
        w_we = 1'b0;
        w_waddr = r_w;
        w_wdata = w_new;
        if (r_state == ST_INIT) begin
            w_we = 1'b1;
            w_wdata = '0;
        end else if (r_state == ST_WORK && (r_op == OP_WRITE || r_op == OP_CLEAR)) begin
            w_we = 1'b1;
            if (r_op == OP_CLEAR) begin
                w_wdata = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr]  <= w_wdata;
            r_ones[w_waddr] <= ones8(w_wdata);
        end
        r_rd_word <= r_mem[r_w];
        r_rd_ones <= r_ones[r_w];
    end

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_answer = r_answer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_w <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_INIT: begin
                    if (r_w == WADDR_W'(NWORDS - 1)) begin
                        r_state <= ST_IDLE;
                        r_w <= '0;
                    end else begin
                        r_w <= r_w + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op <= i_cmd_op;
                        r_lo <= i_cmd_lo;
                        r_hi <= i_cmd_hi;
                        r_w <= i_cmd_w_first;
                        r_last <= i_cmd_w_last;
                        r_val <= i_cmd_val;
                        r_cnt <= '0;
                        r_state <= (i_cmd_op == OP_CLEAR) ? ST_WORK : ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_WORK;
                end
                ST_WORK: begin
                    if (r_op == OP_GET) begin
                        r_answer <= ANSWER_W'((r_rd_word >> (3'd7 - r_lo[2:0])) & 8'd1);
                        r_out_valid <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        if (r_op == OP_COUNT) begin
                            if (w_mask == 8'hFF) begin
                                r_cnt <= r_cnt + CNT_W'(r_rd_ones);
                            end else begin
                                r_cnt <= r_cnt + CNT_W'(ones8(r_rd_word & w_mask));
                            end
                        end
                        if (r_w == r_last) begin
                            if (r_op == OP_COUNT) begin
                                r_out_valid <= 1'b1;
                                r_state <= ST_OUT;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_w <= r_w + 1'b1;
                            r_state <= (r_op == OP_CLEAR) ? ST_WORK : ST_READ;
                        end
                    end
                end
                ST_OUT: begin
                    if (r_op == OP_COUNT && r_out_valid && r_answer == '0 && r_cnt != '0) begin
                        r_answer <= '0;
                    end
                    if (r_op == OP_COUNT && !r_out_valid) begin
                        r_state <= ST_IDLE;
                    end else if (i_ready) begin
                        r_out_valid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (r_state == ST_WORK && r_op == OP_COUNT && r_w == r_last) begin
                if (w_mask == 8'hFF) begin
                    r_answer <= ((r_cnt + CNT_W'(r_rd_ones)) > ANS_MAX) ? ANSWER_W'(ANS_MAX)
                              : ANSWER_W'(r_cnt + CNT_W'(r_rd_ones));
                end else begin
                    r_answer <= ((r_cnt + CNT_W'(ones8(r_rd_word & w_mask))) > ANS_MAX)
                              ? ANSWER_W'(ANS_MAX)
                              : ANSWER_W'(r_cnt + CNT_W'(ones8(r_rd_word & w_mask)));
                end
            end
        end
    end

endmodule

// ===== design/bitset_range_set_count_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitset_range_set_count_unit
// bit store with single bit access, clear, range set and range population count
// ----------------------------------------------------------------------------
// get and count return a result; set, range set and clear only write the store
// per word of the span the back end reads, then works on it; clear skips the read
// rate is set by the single port store memory walk in the back end
// one item in the back end at a time, one more held by the front end
// after reset a clearing pass over every store word runs before the back end takes commands
module bitset_range_set_count_unit
    import brsc_pkg::*;
#(
    parameter int MAX_BITS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [LOW_W-1:0]    i_index_low,
    input  logic [HIGH_W-1:0]   i_index_high,
    input  logic                i_bit_value,
    input  logic [LEN_W-1:0]    i_length,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ANSWER_W-1:0] o_answer
);
    localparam int NWORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W   = WADDR_W + 3;

    logic w_cmd_valid, w_cmd_ready, w_cmd_val;
    t_op w_cmd_op;
    logic [BIT_W-1:0] w_cmd_lo;
    logic [BIT_W:0] w_cmd_hi;
    logic [WADDR_W-1:0] w_cmd_first, w_cmd_last;

    brsc_front #(.MAX_BITS(MAX_BITS), .BIT_W(BIT_W), .WADDR_W(WADDR_W)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_kind, .i_index_low, .i_index_high, .i_bit_value, .i_length,
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd_op(w_cmd_op),
        .o_cmd_lo(w_cmd_lo), .o_cmd_hi(w_cmd_hi), .o_cmd_w_first(w_cmd_first),
        .o_cmd_w_last(w_cmd_last), .o_cmd_val(w_cmd_val)
    );

    brsc_back #(.MAX_BITS(MAX_BITS), .BIT_W(BIT_W), .WADDR_W(WADDR_W)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd_op(w_cmd_op),
        .i_cmd_lo(w_cmd_lo), .i_cmd_hi(w_cmd_hi), .i_cmd_w_first(w_cmd_first),
        .i_cmd_w_last(w_cmd_last), .i_cmd_val(w_cmd_val),
        .o_valid, .i_ready, .o_answer
    );

endmodule
